FILE: src/stok_pkg.sv
package stok_pkg;

	localparam int POSITION_WIDTH = 32;
	localparam int LENGTH_WIDTH   = 16;
	localparam int LINE_WIDTH     = 24;
	localparam int CP_WIDTH       = 21;
	localparam int MAX_TOKENS     = 3;
	localparam int QUEUE_DEPTH    = 8;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	typedef logic [POSITION_WIDTH-1:0] pos_t;
	typedef logic [LENGTH_WIDTH-1:0]   len_t;
	typedef logic [LINE_WIDTH-1:0]     line_t;
	typedef logic [CP_WIDTH-1:0]       cp_t;

	typedef enum logic [3:0] {
		K_IDENT, K_OPER, K_I32, K_U32, K_U64, K_I64, K_F64, K_F32,
		K_STRING, K_EOF, K_ERROR
	} kind_t;

	typedef enum logic [5:0] {
		OP_INC, OP_ADD_EQ, OP_ADD, OP_DEC, OP_SUB_EQ, OP_SUB, OP_MUL_EQ, OP_MUL,
		OP_EQ, OP_ARROW, OP_ASSIGN, OP_NE, OP_NOT, OP_LAND, OP_AND, OP_LOR, OP_OR,
		OP_XOR_EQ, OP_XOR, OP_DIV_EQ, OP_DIV, OP_SHL_EQ, OP_SHL, OP_LE, OP_LT,
		OP_SHR_EQ, OP_SHR, OP_GE, OP_GT, OP_MOD_EQ, OP_MOD, OP_DOT, OP_LPAREN,
		OP_RPAREN, OP_LBRACK, OP_RBRACK, OP_LBRACE, OP_RBRACE, OP_QUEST, OP_TILDE,
		OP_COMMA, OP_COLON
	} op_t;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_IDENT, M_INT, M_DOT, M_FRAC, M_USFX, M_STRING,
		M_OP, M_SHIFT
	} mode_t;

	typedef struct packed {
		logic hit;
		op_t  op;
	} op_hit_t;

	typedef struct packed {
		kind_t kind;
		op_t   op;
		pos_t  start;
		len_t  len;
		line_t line;
		logic  last;
	} tok_t;

	typedef struct packed {
		logic [1:0]                  n;
		tok_t [MAX_TOKENS-1:0]       tok;
	} push_t;

	function automatic logic is_ascii(cp_t c);
		return c[CP_WIDTH-1:8] == '0;
	endfunction

	function automatic logic is_letter(cp_t c);
		return is_ascii(c) && ((c[7:0] >= "a" && c[7:0] <= "z") ||
			(c[7:0] >= "A" && c[7:0] <= "Z") || c[7:0] == "_");
	endfunction

	function automatic logic is_digit(cp_t c);
		return is_ascii(c) && c[7:0] >= "0" && c[7:0] <= "9";
	endfunction

	function automatic logic is_ch(cp_t c, logic [7:0] a);
		return is_ascii(c) && c[7:0] == a;
	endfunction

	// Operators that may take a further character.
	function automatic op_hit_t first_op(cp_t c);
		op_hit_t r;
		r = '{hit: is_ascii(c), op: OP_INC};
		unique case (c[7:0])
			"+": r.op = OP_ADD;
			"-": r.op = OP_SUB;
			"*": r.op = OP_MUL;
			"=": r.op = OP_ASSIGN;
			"!": r.op = OP_NOT;
			"&": r.op = OP_AND;
			"|": r.op = OP_OR;
			"^": r.op = OP_XOR;
			"/": r.op = OP_DIV;
			"<": r.op = OP_LT;
			">": r.op = OP_GT;
			"%": r.op = OP_MOD;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Operators that are always a single character.
	function automatic op_hit_t single_op(cp_t c);
		op_hit_t r;
		r = '{hit: is_ascii(c), op: OP_INC};
		unique case (c[7:0])
			".": r.op = OP_DOT;
			"(": r.op = OP_LPAREN;
			")": r.op = OP_RPAREN;
			"[": r.op = OP_LBRACK;
			"]": r.op = OP_RBRACK;
			"{": r.op = OP_LBRACE;
			"}": r.op = OP_RBRACE;
			"?": r.op = OP_QUEST;
			"~": r.op = OP_TILDE;
			",": r.op = OP_COMMA;
			":": r.op = OP_COLON;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic op_hit_t second_op(op_t p, cp_t c);
		op_hit_t r;
		r = '{hit: 1'b0, op: OP_INC};
		unique case (p)
			OP_ADD: if (is_ch(c, "+")) r = '{1'b1, OP_INC};
				else if (is_ch(c, "=")) r = '{1'b1, OP_ADD_EQ};
			OP_SUB: if (is_ch(c, "-")) r = '{1'b1, OP_DEC};
				else if (is_ch(c, "=")) r = '{1'b1, OP_SUB_EQ};
			OP_MUL: if (is_ch(c, "=")) r = '{1'b1, OP_MUL_EQ};
			OP_ASSIGN: if (is_ch(c, "=")) r = '{1'b1, OP_EQ};
				else if (is_ch(c, ">")) r = '{1'b1, OP_ARROW};
			OP_NOT: if (is_ch(c, "=")) r = '{1'b1, OP_NE};
			OP_AND: if (is_ch(c, "&")) r = '{1'b1, OP_LAND};
			OP_OR: if (is_ch(c, "|")) r = '{1'b1, OP_LOR};
			OP_XOR: if (is_ch(c, "=")) r = '{1'b1, OP_XOR_EQ};
			OP_DIV: if (is_ch(c, "=")) r = '{1'b1, OP_DIV_EQ};
			OP_LT: if (is_ch(c, "<")) r = '{1'b1, OP_SHL};
				else if (is_ch(c, "=")) r = '{1'b1, OP_LE};
			OP_GT: if (is_ch(c, ">")) r = '{1'b1, OP_SHR};
				else if (is_ch(c, "=")) r = '{1'b1, OP_GE};
			OP_MOD: if (is_ch(c, "=")) r = '{1'b1, OP_MOD_EQ};
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/stok_in_if.sv
interface stok_in_if;
	logic                      valid;
	logic                      ready;
	logic [stok_pkg::CP_WIDTH-1:0] code_point;
	logic                      end_of_source;

	modport source (output valid, code_point, end_of_source, input ready);
	modport sink (input valid, code_point, end_of_source, output ready);
endinterface

FILE: src/stok_out_if.sv
interface stok_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [3:0]                            token_kind;
	logic [5:0]                            operator_code;
	logic [stok_pkg::POSITION_WIDTH-1:0]   start_offset;
	logic [stok_pkg::LENGTH_WIDTH-1:0]     token_length;
	logic [stok_pkg::LINE_WIDTH-1:0]       line_number;
	logic                                  last_of_run;

	modport source (output valid, token_kind, operator_code, start_offset, token_length,
		line_number, last_of_run, input ready);
	modport sink (input valid, token_kind, operator_code, start_offset, token_length,
		line_number, last_of_run, output ready);
endinterface

FILE: src/stok_front.sv
module stok_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  stok_pkg::cp_t   cp,
	input  logic            eos,
	output stok_pkg::push_t push
);
	import stok_pkg::*;

	mode_t mode_q, mode_v;
	op_t   pend_q, pend_v;
	kind_t nkind_q, nkind_v;
	pos_t  start_q, start_v, pos_q, pos_v, prev;
	len_t  cnt_q, cnt_v;
	line_t line_q, line_v;
	logic  done;
	logic [1:0] n;
	tok_t [MAX_TOKENS-1:0] t;
	op_hit_t oh;

	function automatic tok_t mk(kind_t k, op_t o, pos_t s, len_t l, line_t ln);
		tok_t r;
		r = '{kind: k, op: o, start: s, len: l, line: ln, last: 1'b0};
		return r;
	endfunction

	function automatic len_t inc(len_t v);
		return (v == '1) ? v : v + len_t'(1);
	endfunction

	always_comb begin
		mode_v = mode_q; pend_v = pend_q; nkind_v = nkind_q; start_v = start_q;
		cnt_v = cnt_q; line_v = line_q; pos_v = pos_q + pos_t'(1);
		prev = pos_q - pos_t'(1);
		done = 1'b1; n = '0; t = '0; oh = '0;
		if (!eos) begin
			unique case (mode_q)
				M_COMMENT: done = !is_ch(cp, 8'h0A);
				M_IDENT: if (is_letter(cp) || is_digit(cp)) cnt_v = inc(cnt_q);
					else done = 1'b0;
				M_INT: begin
					if (is_digit(cp)) cnt_v = inc(cnt_q);
					else if (is_ch(cp, ".")) mode_v = M_DOT;
					else if (is_ch(cp, "i") || is_ch(cp, "l")) begin
						cnt_v = inc(cnt_q);
						t[n] = mk(is_ch(cp, "i") ? K_I32 : K_I64, OP_INC, start_q, cnt_v,
							line_q);
						n = n + 2'd1;
						mode_v = M_IDLE;
					end else if (is_ch(cp, "u")) begin
						cnt_v = inc(cnt_q); nkind_v = K_U32; mode_v = M_USFX;
					end else done = 1'b0;
				end
				M_DOT: if (is_digit(cp)) begin
					cnt_v = inc(inc(cnt_q)); nkind_v = K_F64; mode_v = M_FRAC;
				end else done = 1'b0;
				M_FRAC: begin
					if (is_digit(cp)) cnt_v = inc(cnt_q);
					else if (is_ch(cp, "f")) begin
						cnt_v = inc(cnt_q);
						t[n] = mk(K_F32, OP_INC, start_q, cnt_v, line_q);
						n = n + 2'd1;
						mode_v = M_IDLE;
					end else done = 1'b0;
				end
				M_USFX: if (is_ch(cp, "l")) begin
					cnt_v = inc(cnt_q);
					t[n] = mk(K_U64, OP_INC, start_q, cnt_v, line_q);
					n = n + 2'd1;
					mode_v = M_IDLE;
				end else done = 1'b0;
				M_STRING: begin
					cnt_v = inc(cnt_q);
					if (is_ch(cp, 8'h0A) && line_q != '1) line_v = line_q + line_t'(1);
					if (is_ch(cp, 8'h22)) begin
						t[n] = mk(K_STRING, OP_INC, start_q, cnt_v, line_q);
						n = n + 2'd1;
						mode_v = M_IDLE;
					end
				end
				M_OP: begin
					oh = second_op(pend_q, cp);
					if (oh.hit && (oh.op == OP_SHL || oh.op == OP_SHR)) begin
						pend_v = oh.op; mode_v = M_SHIFT;
					end else if (oh.hit) begin
						t[n] = mk(K_OPER, oh.op, start_q, len_t'(2), line_q);
						n = n + 2'd1;
						mode_v = M_IDLE;
					end else done = 1'b0;
				end
				M_SHIFT: if (is_ch(cp, "=")) begin
					t[n] = mk(K_OPER, (pend_q == OP_SHL) ? OP_SHL_EQ : OP_SHR_EQ, start_q,
						len_t'(3), line_q);
					n = n + 2'd1;
					mode_v = M_IDLE;
				end else done = 1'b0;
				default: done = 1'b0;
			endcase
		end
		if (eos || !done) begin
			// Flush whatever token is still held.
			unique case (mode_q)
				M_IDENT: begin
					t[n] = mk(K_IDENT, OP_INC, start_q, cnt_q, line_q); n = n + 2'd1;
				end
				M_INT, M_FRAC, M_USFX: begin
					t[n] = mk(nkind_q, OP_INC, start_q, cnt_q, line_q); n = n + 2'd1;
				end
				M_DOT: begin
					t[n] = mk(nkind_q, OP_INC, start_q, cnt_q, line_q); n = n + 2'd1;
					t[n] = mk(K_OPER, OP_DOT, prev, len_t'(1), line_q); n = n + 2'd1;
				end
				M_STRING: begin
					t[n] = mk(K_ERROR, OP_INC, start_q, cnt_q, line_q); n = n + 2'd1;
				end
				M_OP: begin
					t[n] = mk(K_OPER, pend_q, start_q, len_t'(1), line_q); n = n + 2'd1;
				end
				M_SHIFT: begin
					t[n] = mk(K_OPER, pend_q, start_q, len_t'(2), line_q); n = n + 2'd1;
				end
				default: ;
			endcase
			mode_v = M_IDLE;
			if (eos) begin
				t[n] = mk(K_EOF, OP_INC, pos_q, '0, line_q); n = n + 2'd1;
				line_v = '0;
				pos_v = '0;
			end else begin
				priority if (is_ch(cp, 8'h0A)) begin
					if (line_q != '1) line_v = line_q + line_t'(1);
				end else if (is_ch(cp, " ") || is_ch(cp, 8'h0D) || is_ch(cp, 8'h09)) begin
				end else if (is_ch(cp, ";")) begin
					mode_v = M_COMMENT;
				end else if (is_letter(cp)) begin
					mode_v = M_IDENT; start_v = pos_q; cnt_v = len_t'(1);
				end else if (is_digit(cp)) begin
					mode_v = M_INT; start_v = pos_q; cnt_v = len_t'(1); nkind_v = K_I32;
				end else if (is_ch(cp, 8'h22)) begin
					mode_v = M_STRING; start_v = pos_q; cnt_v = len_t'(1);
				end else if (is_ch(cp, 8'h27)) begin
					t[n] = mk(K_ERROR, OP_INC, pos_q, len_t'(1), line_q); n = n + 2'd1;
				end else if (first_op(cp).hit) begin
					mode_v = M_OP; start_v = pos_q; cnt_v = len_t'(1);
					pend_v = first_op(cp).op;
				end else if (single_op(cp).hit) begin
					t[n] = mk(K_OPER, single_op(cp).op, pos_q, len_t'(1), line_q);
					n = n + 2'd1;
				end else begin
				end
			end
		end
		for (int i = 0; i < MAX_TOKENS; i++) begin
			t[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
		end
		push.n   = take ? n : 2'd0;
		push.tok = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= OP_INC; nkind_q <= K_I32;
			start_q <= '0; cnt_q <= '0; line_q <= '0; pos_q <= '0;
		end else if (take) begin
			mode_q <= mode_v; pend_q <= pend_v; nkind_q <= nkind_v;
			start_q <= start_v; cnt_q <= cnt_v; line_q <= line_v; pos_q <= pos_v;
		end
	end
endmodule

FILE: src/stok_queue.sv
module stok_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  stok_pkg::push_t push,
	output logic            room,
	output logic            head_valid,
	output stok_pkg::tok_t  head,
	input  logic            pop
);
	import stok_pkg::*;

	tok_t mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_pop;

	assign head_valid = count_q != '0;
	assign head       = mem[rd_q];
	assign do_pop     = pop && head_valid;
	assign room       = count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_TOKENS);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOKENS; i++) begin
			if (2'(i) < push.n) mem[wr_q + QUEUE_AW'(i)] <= push.tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			wr_q    <= wr_q + QUEUE_AW'(push.n);
			rd_q    <= rd_q + QUEUE_AW'(do_pop);
			count_q <= count_q + (QUEUE_AW+1)'(push.n) - (QUEUE_AW+1)'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("token queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room) else $error("push without room");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !pop |=> head_valid && $stable(rd_q)) else $error("head lost");
endmodule

FILE: src/source_token_scanner.sv
// Streaming scanner: one code point (or an end-of-source mark) is taken per
// transfer on src, and each transfer may complete up to three tokens, which
// leave one per transfer on tok. The front part holds the scanning state and
// decides every item combinationally, so an item can be taken each clock;
// the tokens go into an eight-entry queue that the output side drains at one
// token per cycle. Input is held off only while the queue has fewer than
// three free entries, so the sustained rate is one item per cycle whenever
// items yield on average no more than one token and the sink keeps up.
// Keywords come out as identifiers, a single quote gives an error token, and
// unknown characters are dropped. After end-of-source the position and line
// counters restart at zero.
module source_token_scanner (
	input logic     clk,
	input logic     arst_n,
	stok_in_if.sink   src,
	stok_out_if.source tok
);
	import stok_pkg::*;

	push_t push;
	tok_t  head;
	logic  room;
	logic  take;

	// A transfer on the input happens when the queue can absorb a worst case item.
	assign src.ready = room;
	assign take      = src.valid && room;

	stok_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.cp     (src.code_point),
		.eos    (src.end_of_source),
		.push   (push)
	);

	stok_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (tok.valid),
		.head       (head),
		.pop        (tok.ready)
	);

	// Token fields come straight from the queue head.
	assign tok.token_kind    = head.kind;
	assign tok.operator_code = head.op;
	assign tok.start_offset  = head.start;
	assign tok.token_length  = head.len;
	assign tok.line_number   = head.line;
	assign tok.last_of_run   = head.last;
endmodule

FILE: bench/source_token_scanner_tb.sv
module source_token_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stok_pkg::*;

	// One row of the directed part. Where fixed is set, the token in want is the
	// only one this character may produce; otherwise the scanner model decides.
	typedef struct {
		cp_t  cp;
		bit   eos;
		bit   fixed;
		tok_t want;
	} stim_row_t;

	typedef struct {
		cp_t cp;
		bit  eos;
	} char_t;

	logic clk;
	logic arst_n;

	stok_in_if  src ();
	stok_out_if tok ();

	source_token_scanner DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.tok    (tok)
	);

	always #5 clk = ~clk;

	// Scanner state, kept in step with every transfer accepted on the input side.
	mode_t scan_state;
	op_t   held_op;
	kind_t num_kind;
	pos_t  tok_start;
	len_t  lex_len;
	line_t line_cnt;
	pos_t  char_pos;

	tok_t  step_toks[$];
	tok_t  pending_toks[$];
	char_t char_q[$];
	int    error_count;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic bit is_alpha(cp_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_num(cp_t c);
		return c >= "0" && c <= "9";
	endfunction

	// Operators that may grow by a further character.
	function automatic bit lead_op(cp_t c, output op_t o);
		o = OP_INC;
		case (c)
			"+": o = OP_ADD;
			"-": o = OP_SUB;
			"*": o = OP_MUL;
			"=": o = OP_ASSIGN;
			"!": o = OP_NOT;
			"&": o = OP_AND;
			"|": o = OP_OR;
			"^": o = OP_XOR;
			"/": o = OP_DIV;
			"<": o = OP_LT;
			">": o = OP_GT;
			"%": o = OP_MOD;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic bit lone_op(cp_t c, output op_t o);
		o = OP_INC;
		case (c)
			".": o = OP_DOT;
			"(": o = OP_LPAREN;
			")": o = OP_RPAREN;
			"[": o = OP_LBRACK;
			"]": o = OP_RBRACK;
			"{": o = OP_LBRACE;
			"}": o = OP_RBRACE;
			"?": o = OP_QUEST;
			"~": o = OP_TILDE;
			",": o = OP_COMMA;
			":": o = OP_COLON;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic bit join_op(op_t p, cp_t c, output op_t o);
		o = OP_INC;
		case (p)
			OP_ADD: if (c == "+") o = OP_INC; else if (c == "=") o = OP_ADD_EQ;
				else return 1'b0;
			OP_SUB: if (c == "-") o = OP_DEC; else if (c == "=") o = OP_SUB_EQ;
				else return 1'b0;
			OP_MUL: if (c == "=") o = OP_MUL_EQ; else return 1'b0;
			OP_ASSIGN: if (c == "=") o = OP_EQ; else if (c == ">") o = OP_ARROW;
				else return 1'b0;
			OP_NOT: if (c == "=") o = OP_NE; else return 1'b0;
			OP_AND: if (c == "&") o = OP_LAND; else return 1'b0;
			OP_OR: if (c == "|") o = OP_LOR; else return 1'b0;
			OP_XOR: if (c == "=") o = OP_XOR_EQ; else return 1'b0;
			OP_DIV: if (c == "=") o = OP_DIV_EQ; else return 1'b0;
			OP_LT: if (c == "<") o = OP_SHL; else if (c == "=") o = OP_LE;
				else return 1'b0;
			OP_GT: if (c == ">") o = OP_SHR; else if (c == "=") o = OP_GE;
				else return 1'b0;
			OP_MOD: if (c == "=") o = OP_MOD_EQ; else return 1'b0;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// At most three tokens can come out of one character; any further ones are lost.
	function automatic void add_token(kind_t k, op_t o, pos_t s, len_t n);
		tok_t t;
		if (step_toks.size() < MAX_TOKENS) begin
			t = '{kind: k, op: o, start: s, len: n, line: line_cnt, last: 1'b0};
			step_toks.push_back(t);
		end
	endfunction

	function automatic void bump_len();
		if (lex_len != '1)
			lex_len++;
	endfunction

	function automatic void bump_line();
		if (line_cnt != '1)
			line_cnt++;
	endfunction

	// Whatever token is still open is closed off; a held '.' after an integer
	// becomes an operator of its own at dot_at.
	function automatic void close_open(pos_t dot_at);
		case (scan_state)
			M_IDENT: add_token(K_IDENT, OP_INC, tok_start, lex_len);
			M_INT, M_FRAC, M_USFX: add_token(num_kind, OP_INC, tok_start, lex_len);
			M_DOT: begin
				add_token(num_kind, OP_INC, tok_start, lex_len);
				add_token(K_OPER, OP_DOT, dot_at, 1);
			end
			M_STRING: add_token(K_ERROR, OP_INC, tok_start, lex_len);
			M_OP: add_token(K_OPER, held_op, tok_start, 1);
			M_SHIFT: add_token(K_OPER, held_op, tok_start, 2);
			default: ;
		endcase
		scan_state = M_IDLE;
	endfunction

	function automatic void open_token(mode_t m, pos_t p);
		scan_state = m;
		tok_start = p;
		lex_len = 1;
	endfunction

	function automatic void begin_fresh(cp_t c, pos_t p);
		op_t o;
		scan_state = M_IDLE;
		if (c == "\n")
			bump_line();
		else if (c == " " || c == "\r" || c == "\t")
			;
		else if (c == ";")
			scan_state = M_COMMENT;
		else if (is_alpha(c))
			open_token(M_IDENT, p);
		else if (is_num(c)) begin
			open_token(M_INT, p);
			num_kind = K_I32;
		end else if (c == "\"")
			open_token(M_STRING, p);
		else if (c == "'")
			add_token(K_ERROR, OP_INC, p, 1);
		else if (lead_op(c, o)) begin
			open_token(M_OP, p);
			held_op = o;
		end else if (lone_op(c, o))
			add_token(K_OPER, o, p, 1);
	endfunction

	// Advances the scanner by one character and leaves its tokens in step_toks.
	function automatic void scan_char(cp_t c, bit eos);
		pos_t p;
		pos_t prev;
		bit   kept;
		op_t  o;
		p = char_pos;
		prev = p - 1;
		kept = 1'b1;
		step_toks.delete();
		if (eos) begin
			close_open(prev);
			add_token(K_EOF, OP_INC, p, 0);
			line_cnt = 0;
			char_pos = 0;
		end else begin
			case (scan_state)
				M_COMMENT: kept = (c != "\n");
				M_IDENT: if (is_alpha(c) || is_num(c)) bump_len(); else kept = 1'b0;
				M_INT: begin
					if (is_num(c))
						bump_len();
					else if (c == ".")
						scan_state = M_DOT;
					else if (c == "i" || c == "l") begin
						bump_len();
						add_token(c == "i" ? K_I32 : K_I64, OP_INC, tok_start, lex_len);
						scan_state = M_IDLE;
					end else if (c == "u") begin
						bump_len();
						num_kind = K_U32;
						scan_state = M_USFX;
					end else
						kept = 1'b0;
				end
				M_DOT: begin
					if (is_num(c)) begin
						bump_len();
						bump_len();
						num_kind = K_F64;
						scan_state = M_FRAC;
					end else
						kept = 1'b0;
				end
				M_FRAC: begin
					if (is_num(c))
						bump_len();
					else if (c == "f") begin
						bump_len();
						add_token(K_F32, OP_INC, tok_start, lex_len);
						scan_state = M_IDLE;
					end else
						kept = 1'b0;
				end
				M_USFX: begin
					if (c == "l") begin
						bump_len();
						add_token(K_U64, OP_INC, tok_start, lex_len);
						scan_state = M_IDLE;
					end else
						kept = 1'b0;
				end
				M_STRING: begin
					bump_len();
					if (c == "\n")
						bump_line();
					if (c == "\"") begin
						add_token(K_STRING, OP_INC, tok_start, lex_len);
						scan_state = M_IDLE;
					end
				end
				M_OP: begin
					if (join_op(held_op, c, o)) begin
						if (o == OP_SHL || o == OP_SHR) begin
							held_op = o;
							scan_state = M_SHIFT;
						end else begin
							add_token(K_OPER, o, tok_start, 2);
							scan_state = M_IDLE;
						end
					end else
						kept = 1'b0;
				end
				M_SHIFT: begin
					// The assigning shift sits just below the plain shift in the code list.
					if (c == "=") begin
						add_token(K_OPER, op_t'(held_op - 1), tok_start, 3);
						scan_state = M_IDLE;
					end else
						kept = 1'b0;
				end
				default: kept = 1'b0;
			endcase
			if (!kept) begin
				close_open(prev);
				begin_fresh(c, p);
			end
			char_pos = p + 1;
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size()-1].last = 1'b1;
	endfunction

	// Directed part. The first three rows need no model: end of source straight
	// after reset, a single quote at position zero, and a bracket after it.
	stim_row_t directed_tab[] = '{
		'{21'h0, 1'b1, 1'b1, '{K_EOF, OP_INC, 32'd0, 16'd0, 24'd0, 1'b1}},
		'{21'h27, 1'b0, 1'b1, '{K_ERROR, OP_INC, 32'd0, 16'd1, 24'd0, 1'b1}},
		'{21'h28, 1'b0, 1'b1, '{K_OPER, OP_LPAREN, 32'd1, 16'd1, 24'd0, 1'b1}},
		'{21'h10FFFF, 1'b0, 1'b0, '0},
		'{21'h0F0000, 1'b0, 1'b0, '0},
		'{21'h0, 1'b0, 1'b0, '0},
		'{21'h3C, 1'b0, 1'b0, '0},
		'{21'h3C, 1'b0, 1'b0, '0},
		'{21'h3D, 1'b0, 1'b0, '0},
		'{21'h31, 1'b0, 1'b0, '0},
		'{21'h2E, 1'b0, 1'b0, '0},
		'{21'h35, 1'b0, 1'b0, '0},
		'{21'h66, 1'b0, 1'b0, '0},
		'{21'h33, 1'b0, 1'b0, '0},
		'{21'h75, 1'b0, 1'b0, '0},
		'{21'h6C, 1'b0, 1'b0, '0},
		'{21'h34, 1'b0, 1'b0, '0},
		'{21'h2E, 1'b0, 1'b0, '0},
		'{21'h78, 1'b0, 1'b0, '0},
		'{21'h22, 1'b0, 1'b0, '0},
		'{21'h0A, 1'b0, 1'b0, '0},
		'{21'h3B, 1'b0, 1'b0, '0},
		'{21'h22, 1'b0, 1'b0, '0},
		'{21'h3B, 1'b0, 1'b0, '0},
		'{21'h0A, 1'b0, 1'b0, '0},
		'{21'h22, 1'b0, 1'b0, '0},
		'{21'h0, 1'b1, 1'b0, '0}
	};

	string op_text[42] = '{"++", "+=", "+", "--", "-=", "-", "*=", "*", "==", "=>",
		"=", "!=", "!", "&&", "&", "||", "|", "^=", "^", "/=", "/", "<<=", "<<",
		"<=", "<", ">>=", ">>", ">=", ">", "%=", "%", ".", "(", ")", "[", "]", "{",
		"}", "?", "~", ",", ":"};

	function automatic void add_text(string s);
		foreach (s[i])
			char_q.push_back('{cp_t'(s[i]), 1'b0});
	endfunction

	function automatic string pick_from(string set);
		return set.substr(0, 0).len() == 0 ? "" : string'(set[$urandom_range(0, set.len() - 1)]);
	endfunction

	// One lexeme of random content; most are well formed, a few are noise.
	function automatic void add_lexeme();
		string s;
		int    n;
		string suffixes[8] = '{"", "i", "l", "u", "ul", ".7", ".25f", "."};
		s = "";
		case ($urandom_range(0, 11))
			0, 1: begin
				n = $urandom_range(1, 6);
				s = pick_from("abcdefiluxyzAZ_");
				repeat (n - 1) s = {s, pick_from("abfiluz_Q09")};
			end
			2, 3: begin
				n = $urandom_range(1, 4);
				repeat (n) s = {s, pick_from("0123456789")};
				s = {s, suffixes[$urandom_range(0, 7)]};
			end
			4, 5: s = op_text[$urandom_range(0, 41)];
			6: begin
				s = "\"";
				repeat ($urandom_range(0, 5)) s = {s, pick_from("ab ;\n9+'")};
				s = {s, "\""};
			end
			7: begin
				s = ";";
				repeat ($urandom_range(0, 4)) s = {s, pick_from("x \"'+")};
				s = {s, "\n"};
			end
			8: s = "'";
			9: s = pick_from(" \t\r\n");
			default: begin
				char_q.push_back('{cp_t'($urandom_range(0, 1114111)), 1'b0});
				return;
			end
		endcase
		add_text(s);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// One input transfer: optional gap, then valid held until ready is seen.
	task automatic send_char(cp_t c, bit eos, int gap);
		if (gap > 0) begin
			src.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src.valid <= 1'b1;
		src.code_point <= c;
		src.end_of_source <= eos;
		do
			@(posedge clk);
		while (!src.ready);
		scan_char(c, eos);
	endtask

	// Output side: random stalls, mostly short, some long, with quiet stretches.
	int stall_left;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			tok.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			tok.ready <= 1'b1;
			case ($urandom_range(0, 59))
				0, 1, 2, 3, 4, 5, 6, 7: stall_left <= $urandom_range(1, 3);
				8: stall_left <= $urandom_range(20, 60);
				default: ;
			endcase
		end
	end

	// Every token transfer is checked against the oldest one expected.
	always @(posedge clk) begin
		tok_t want;
		if (arst_n && tok.valid && tok.ready) begin
			if (pending_toks.size() == 0)
				report($sformatf("token kind %0d at %0d with nothing expected",
					tok.token_kind, tok.start_offset));
			else begin
				want = pending_toks.pop_front();
				if (tok.token_kind !== want.kind)
					report($sformatf("kind %0d, expected %s", tok.token_kind, want.kind.name()));
				if (tok.operator_code !== want.op)
					report($sformatf("operator %0d, expected %s", tok.operator_code,
						want.op.name()));
				if (tok.start_offset !== want.start)
					report($sformatf("start %0d, expected %0d", tok.start_offset, want.start));
				if (tok.token_length !== want.len)
					report($sformatf("length %0d, expected %0d", tok.token_length, want.len));
				if (tok.line_number !== want.line)
					report($sformatf("line %0d, expected %0d", tok.line_number, want.line));
				if (tok.last_of_run !== want.last)
					report($sformatf("last %0b, expected %0b", tok.last_of_run, want.last));
			end
		end
	end

	initial begin
		#5ms;
		$display("source_token_scanner regression: fail");
		$finish;
	end

	initial begin
		int  wait_cycles;
		clk = 1'b0;
		arst_n = 1'b0;
		src.valid = 1'b0;
		src.code_point = '0;
		src.end_of_source = 1'b0;
		tok.ready = 1'b0;
		stall_left = 0;
		error_count = 0;
		scan_state = M_IDLE;
		held_op = OP_INC;
		num_kind = K_I32;
		tok_start = '0;
		lex_len = '0;
		line_cnt = '0;
		char_pos = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tab[i]) begin
			send_char(directed_tab[i].cp, directed_tab[i].eos, pick_gap());
			if (directed_tab[i].fixed)
				pending_toks.push_back(directed_tab[i].want);
			else
				foreach (step_toks[j]) pending_toks.push_back(step_toks[j]);
		end

		// Random source text, broken now and then by an end of source.
		while (char_q.size() < 260) begin
			add_lexeme();
			if ($urandom_range(0, 2) == 0)
				add_text(" ");
			if ($urandom_range(0, 24) == 0)
				char_q.push_back('{cp_t'($urandom_range(0, 1114111)), 1'b1});
		end
		char_q.push_back('{cp_t'(0), 1'b1});
		foreach (char_q[i]) begin
			// Every fiftieth character starts a stretch sent without gaps.
			send_char(char_q[i].cp, char_q[i].eos, (i % 50) < 15 ? 0 : pick_gap());
			foreach (step_toks[j]) pending_toks.push_back(step_toks[j]);
		end
		src.valid <= 1'b0;

		wait_cycles = 0;
		while (pending_toks.size() > 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_toks.size() > 0)
			report($sformatf("%0d tokens never arrived", pending_toks.size()));
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("source_token_scanner regression: pass");
		else
			$display("source_token_scanner regression: fail");
		$finish;
	end

endmodule
